### hw/rtl/bei_pkg.sv
package bei_pkg;

    localparam int BYTE_W             = 8;
    localparam int CFG_W              = 64;
    localparam int SET_W              = 256;
    localparam int PLEN_W             = 4;
    localparam int REG_IDX_W          = 3;
    localparam int MAX_PREFIX_LEN_DEF = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SET_0_63     = 3'd0,
        REG_SET_64_127   = 3'd1,
        REG_SET_128_191  = 3'd2,
        REG_SET_192_255  = 3'd3,
        REG_PREFIX_BYTES = 3'd4,
        REG_PREFIX_LEN   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [SET_W-1:0]  set_bits;
        logic [CFG_W-1:0]  prefix_bytes;
        logic [PLEN_W-1:0] prefix_len;
    } t_cfg;

endpackage

### hw/rtl/bei_if.sv
interface bei_in_if;
    logic             valid;
    logic             ready;
    bei_pkg::t_byte   data_byte;
    logic             string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface bei_out_if;
    logic             valid;
    logic             ready;
    bei_pkg::t_byte   out_byte;
    logic             run_last;
    logic             string_last;

    modport source (output valid, output out_byte, output run_last, output string_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_last,
                    output ready);
endinterface

### hw/rtl/bei_cfg.sv
module bei_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bei_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bei_pkg::CFG_W-1:0]       i_cfg_data,
    output bei_pkg::t_cfg                   o_cfg
);

    bei_pkg::t_cfg r_cfg;
    bei_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (bei_pkg::t_reg_idx'(i_cfg_idx))
                bei_pkg::REG_SET_0_63:     n_cfg.set_bits[63:0]    = i_cfg_data;
                bei_pkg::REG_SET_64_127:   n_cfg.set_bits[127:64]  = i_cfg_data;
                bei_pkg::REG_SET_128_191:  n_cfg.set_bits[191:128] = i_cfg_data;
                bei_pkg::REG_SET_192_255:  n_cfg.set_bits[255:192] = i_cfg_data;
                bei_pkg::REG_PREFIX_BYTES: n_cfg.prefix_bytes      = i_cfg_data;
                bei_pkg::REG_PREFIX_LEN:   n_cfg.prefix_len =
                                               i_cfg_data[bei_pkg::PLEN_W-1:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/bei_emit.sv
module bei_emit #(
    parameter int MAX_PREFIX_LEN = bei_pkg::MAX_PREFIX_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bei_pkg::t_cfg i_cfg,
    bei_in_if.sink        i_item,
    bei_out_if.source     o_item
);

    localparam int CW = $clog2(MAX_PREFIX_LEN + 1);
    localparam int IW = (MAX_PREFIX_LEN > 1) ? $clog2(MAX_PREFIX_LEN) : 1;

    bei_pkg::t_byte prefix_arr [MAX_PREFIX_LEN];

    logic           r_a_valid;
    bei_pkg::t_byte r_a_byte;
    logic           r_a_end;
    logic           r_a_dbl;
    logic [CW-1:0]  r_a_npre;
    logic [CW-1:0]  r_a_idx;

    logic           n_a_valid;
    bei_pkg::t_byte n_a_byte;
    logic           n_a_end;
    logic           n_a_dbl;
    logic [CW-1:0]  n_a_npre;
    logic [CW-1:0]  n_a_idx;

    logic           r_o_valid;
    bei_pkg::t_byte r_o_byte;
    logic           r_o_run_last;
    logic           r_o_str_last;

    logic           n_o_valid;
    bei_pkg::t_byte n_o_byte;
    logic           n_o_run_last;
    logic           n_o_str_last;

    logic           esc_hit;
    logic [CW-1:0]  plen_sat;
    logic           a_last;
    logic           out_free;
    logic           a_move;
    logic           in_ready;
    logic           in_acc;

    always_comb begin
        for (int i = 0; i < MAX_PREFIX_LEN; i++) begin
            prefix_arr[i] = i_cfg.prefix_bytes[i*bei_pkg::BYTE_W +: bei_pkg::BYTE_W];
        end
    end

    assign esc_hit  = i_cfg.set_bits[i_item.data_byte];
    assign plen_sat = (i_cfg.prefix_len > bei_pkg::PLEN_W'(MAX_PREFIX_LEN))
                    ? CW'(MAX_PREFIX_LEN) : CW'(i_cfg.prefix_len);

    assign a_last   = (r_a_idx == r_a_npre);
    assign out_free = !r_o_valid || o_item.ready;
    assign a_move   = r_a_valid && out_free;
    assign in_ready = !r_a_valid || (a_move && a_last);
    assign in_acc   = i_item.valid && in_ready;

    always_comb begin
        n_a_valid = r_a_valid;
        n_a_byte  = r_a_byte;
        n_a_end   = r_a_end;
        n_a_dbl   = r_a_dbl;
        n_a_npre  = r_a_npre;
        n_a_idx   = r_a_idx;
        priority if (in_acc) begin
            n_a_valid = 1'b1;
            n_a_byte  = i_item.data_byte;
            n_a_end   = i_item.string_end;
            n_a_dbl   = (plen_sat == '0);
            n_a_npre  = !esc_hit ? '0 : ((plen_sat == '0) ? CW'(1) : plen_sat);
            n_a_idx   = '0;
        end else if (a_move && a_last) begin
            n_a_valid = 1'b0;
        end else if (a_move) begin
            n_a_idx   = r_a_idx + CW'(1);
        end else begin
            n_a_valid = r_a_valid;
        end
    end

    always_comb begin
        n_o_valid    = r_o_valid;
        n_o_byte     = r_o_byte;
        n_o_run_last = r_o_run_last;
        n_o_str_last = r_o_str_last;
        priority if (a_move) begin
            n_o_valid = 1'b1;
            if (a_last) begin
                n_o_byte     = r_a_byte;
                n_o_run_last = 1'b1;
                n_o_str_last = r_a_end;
            end else begin
                n_o_byte     = r_a_dbl ? r_a_byte : prefix_arr[r_a_idx[IW-1:0]];
                n_o_run_last = 1'b0;
                n_o_str_last = 1'b0;
            end
        end else if (o_item.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_byte     <= n_a_byte;
        r_a_end      <= n_a_end;
        r_a_dbl      <= n_a_dbl;
        r_a_npre     <= n_a_npre;
        r_a_idx      <= n_a_idx;
        r_o_byte     <= n_o_byte;
        r_o_run_last <= n_o_run_last;
        r_o_str_last <= n_o_str_last;
    end

    assign i_item.ready       = in_ready;
    assign o_item.valid       = r_o_valid;
    assign o_item.out_byte    = r_o_byte;
    assign o_item.run_last    = r_o_run_last;
    assign o_item.string_last = r_o_str_last;

endmodule

### hw/rtl/byte_escape_inserter_unit.sv
// Byte escape inserter.
// i_item carries one byte of a string per item (data_byte, string_end).
// o_item carries the results: out_byte, run_last on the last result of an
// input byte, string_last on that last result when the input closed a string.
// A byte marked in the 256-bit escape set is preceded by the configured escape
// sequence (1 to MAX_PREFIX_LEN bytes); with escape length zero it goes out
// twice. Other bytes go out once.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per cycle;
// write only while no item is in flight.
// The first result of an item passes through the emit stage register and then
// the output register.
// Throughput: one result per cycle from the single emit stage while results
// are taken; a plain byte gives one result, an escaped byte prefix length + 1
// (2 when doubled); the input is held off while an escaped byte emits.
// Reset clears all configuration and empties the stages.
// A stalled receiver holds the output register; one more item is taken into
// the emit stage, after which i_item.ready drops until results move on.
module byte_escape_inserter_unit #(
    parameter int MAX_PREFIX_LEN = bei_pkg::MAX_PREFIX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bei_in_if.sink                          i_item,
    bei_out_if.source                       o_item,
    input  logic                            i_cfg_we,
    input  logic [bei_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bei_pkg::CFG_W-1:0]       i_cfg_data
);

    bei_pkg::t_cfg cfg;

    bei_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bei_emit #(
        .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (i_item),
        .o_item  (o_item)
    );

endmodule

### hw/rtl/bei_checker.sv
module bei_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input bei_pkg::t_byte       out_byte,
    input logic                 run_last,
    input logic                 string_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(string_last))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_str_on_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && string_last |-> run_last)
        else $error("string end off the last result of a run");

    // a run continues without a gap
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside a run");

endmodule

bind byte_escape_inserter_unit bei_checker u_bei_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .out_valid   (o_item.valid),
    .out_ready   (o_item.ready),
    .out_byte    (o_item.out_byte),
    .run_last    (o_item.run_last),
    .string_last (o_item.string_last)
);
